/* hw/rtl/rdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  // Field and register widths fixed by the block's definition.
  localparam int DIGIT_W   = 4;
  localparam int RADIX_W   = 4;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Bits of the dividend consumed by the long-division step in one cycle.
  localparam int CHUNK_BITS = 8;

  // Register map: the register index is byte address bit 2.
  localparam logic REG_RADIX = 1'b0;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(9);

  // Job handed from the front queue to the back end.
  typedef struct packed {
    logic valid;
    logic zero;
  } rdc_job_t;

  // Status of the back end, watched at the top level.
  typedef struct packed {
    logic dividing;
    logic rd_pend;
  } rdc_back_st_t;

  // Register values outside the useful range are clamped to the nearest base.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rdc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rdc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rdc_front
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] value,
  output rdc_job_t                   job,
  output logic      [VALUE_BITS-1:0] job_value,
  input  wire logic                  pop
);

  // Two-entry queue; each entry carries the word and whether it is zero.
  logic [VALUE_BITS-1:0] val_q  [2];
  logic                  zero_q [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            cnt;
  logic                  push;

  assign in_stall  = (cnt == 2'd2);
  assign push      = in_valid && !in_stall;
  assign job.valid = (cnt != 2'd0);
  assign job.zero  = zero_q[rd_ptr];
  assign job_value = val_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        val_q[wr_ptr]  <= value;
        zero_q[wr_ptr] <= (value == '0);
        wr_ptr         <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rdc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module rdc_div
  import rdc_pkg::*;
(
  input  wire logic [RADIX_W-1:0]    radix,
  input  wire logic [DIGIT_W-1:0]    rem_in,
  input  wire logic [CHUNK_BITS-1:0] bits,
  output logic      [DIGIT_W-1:0]    rem_out,
  output logic      [CHUNK_BITS-1:0] quo
);

  // Restoring long division of a chunk by a base below ten; the partial
  // remainder never exceeds twice the base, so five bits suffice.
  always_comb begin
    logic [DIGIT_W:0] r;
    r   = {1'b0, rem_in};
    quo = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], bits[i]};
      if (r >= {1'b0, radix}) begin
        r      = r - {1'b0, radix};
        quo[i] = 1'b1;
      end
    end
    rem_out = r[DIGIT_W-1:0];
  end

endmodule

`default_nettype wire

/* hw/rtl/rdc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module rdc_back
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [RADIX_W-1:0]    radix,
  input  wire rdc_job_t              job,
  input  wire logic [VALUE_BITS-1:0] job_value,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [DIGIT_W-1:0]    digit,
  output logic                       last_digit,
  output rdc_back_st_t               st
);

  localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int WORK_W = NCHUNK * CHUNK_BITS;
  localparam int CI_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state;
  logic [WORK_W-1:0]   work;
  logic [DIGIT_W-1:0]  rem;
  logic [CI_W-1:0]     ci;
  logic [CNT_W-1:0]    count;
  logic                zero_job;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_pend;
  logic                rd_last;

  logic [DIGIT_W-1:0]    rem_out;
  logic [CHUNK_BITS-1:0] quo;
  logic [WORK_W-1:0]     work_next;
  logic                  issue;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [DIGIT_W-1:0]    wdata;
  logic [DIGIT_W-1:0]    rdata;

  rdc_div u_div (
    .radix  (radix),
    .rem_in (rem),
    .bits   (work[WORK_W-1 -: CHUNK_BITS]),
    .rem_out(rem_out),
    .quo    (quo)
  );

  rdc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (issue),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  // Quotient bits shift in at the bottom, so after all chunks the work
  // register holds the full quotient.
  assign work_next = (work << CHUNK_BITS) | WORK_W'(quo);
  assign pop       = (state == S_IDLE) && job.valid;
  assign st.dividing = (state == S_DIV);
  assign st.rd_pend  = rd_pend;

  always_comb begin
    issue = (state == S_EMIT) && !rd_pend && (!out_valid || !out_stall);
    we    = 1'b0;
    waddr = count[IDX_W-1:0];
    wdata = rem_out;
    if (state == S_DIV) begin
      if (zero_job) begin
        we    = 1'b1;
        waddr = '0;
        wdata = '0;
      end else if (ci == '0) begin
        we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (rd_pend) begin
        out_valid  <= 1'b1;
        digit      <= rdata;
        last_digit <= rd_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (job.valid) begin
            work     <= WORK_W'(job_value);
            zero_job <= job.zero;
            rem      <= '0;
            ci       <= CI_W'(NCHUNK - 1);
            count    <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (zero_job) begin
            count  <= CNT_W'(1);
            rd_idx <= '0;
            state  <= S_EMIT;
          end else begin
            work <= work_next;
            if (ci == '0) begin
              count <= count + 1'b1;
              rem   <= '0;
              ci    <= CI_W'(NCHUNK - 1);
              if (work_next == '0 || count == CNT_W'(MAX_DIGITS - 1)) begin
                rd_idx <= count[IDX_W-1:0];
                state  <= S_EMIT;
              end
            end else begin
              rem <= rem_out;
              ci  <= ci - 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (issue) begin
            rd_last <= (rd_idx == '0);
            if (rd_idx == '0) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/radix_digit_converter_core.sv */
`timescale 1ns / 1ps
// Binary to base-N digit converter, base 2 to 9 set by the radix register.
// Input channel: in_valid / in_stall carry one word, value, the integer to
// convert. A word is taken at a clock edge with in_valid high and in_stall
// low. A two-word queue sits in front, so words are taken while a result is
// still being worked on or waits at the output.
// Output channel: out_valid / out_stall carry one digit per word, most
// significant first; last_digit marks the least significant digit. A zero
// input gives a single digit 0 with last_digit set.
// Timing: the remainder is produced by long division, eight dividend bits per
// cycle. The digits are then read back from the digit store one at a time,
// a new read only once the previous one has landed in the output register,
// set by its registered read port. The first digit appears after all digits
// are known. A stalled output holds its word and the read-back pauses; the
// next item's division may start as soon as the last digit has been read.
// Reset (rst, synchronous) empties the queue, idles the back end, drops any
// pending output word and sets radix to 2. No clearing pass is needed.
// Configuration: APB register 0 (byte address 0) holds radix; values below
// 2 act as 2 and above 9 as 9. Write it only while the block is idle.
`default_nettype none

module radix_digit_converter_core
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [DIGIT_W-1:0]    digit,
  output logic                       last_digit
);

  logic [RADIX_W-1:0]    radix;
  logic [RADIX_W-1:0]    radix_eff;
  rdc_job_t              job;
  logic [VALUE_BITS-1:0] job_value;
  logic                  pop;
  rdc_back_st_t          back_st;

  // Configuration register. Address bits below bit 2 are ignored; bit 2 is
  // the register index, and only index 0 exists.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIX) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  assign prdata    = (paddr[2] == REG_RADIX) ? APB_DATA_W'(radix) : '0;
  assign radix_eff = eff_radix(radix);

  // Front end: takes words and marks the zero case.
  rdc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .job      (job),
    .job_value(job_value),
    .pop      (pop)
  );

  // Back end: repeated division into the digit store, then read-back.
  rdc_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix_eff),
    .job       (job),
    .job_value (job_value),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit     (digit),
    .last_digit(last_digit),
    .st        (back_st)
  );

  // The back end only takes a job that the queue actually holds.
  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> job.valid)
    else $error("job taken from an empty queue");

  // A word accepted at the input leaves the queue non-empty.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> job.valid)
    else $error("accepted word missing from the queue");

  // A store read is only issued when the output register is free to take it.
  a_read_lands_free: assert property (@(posedge clk) disable iff (rst)
    back_st.rd_pend |-> !out_valid)
    else $error("store read would overwrite a waiting output word");

  // Read-back of one item never overlaps the division of the next.
  a_no_read_in_div: assert property (@(posedge clk) disable iff (rst)
    back_st.dividing |-> !back_st.rd_pend)
    else $error("store read outstanding while dividing");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rdc_pkg::*;

  localparam int VALUE_BITS  = 31;
  localparam int MAX_DIGITS  = 31;
  localparam int CLK_PERIOD  = 4;
  localparam int RESET_CYCLES = 6;
  // Limit on the length of the whole run, leaving room for the slowest items
  // under the worst stall patterns.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles let pass once the last digit has come, before a register write
  // and at the end of the run.
  localparam int SETTLE_CYCLES = 16;
  // Register index past the end of the map; a write there must be ignored.
  localparam int unsigned SPARE_INDEX = 1;
  localparam int MAX_PRINTED = 40;

  typedef logic [VALUE_BITS-1:0] value_t;

  // One digit word as it is expected on the output channel.
  typedef struct {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } digit_word_t;

  // Scoreboard: keeps its own copy of the radix register and turns every
  // accepted value into the digit words it should produce, in output order.
  class digit_scoreboard;
    digit_word_t        pending_digits[$];
    logic [RADIX_W-1:0] radix_reg;
    int                 errors;

    function new();
      radix_reg = RADIX_RESET;
      errors    = 0;
    endfunction

    function void write_reg(input int unsigned index, input logic [APB_DATA_W-1:0] data);
      if (index == REG_RADIX) begin
        radix_reg = data[RADIX_W-1:0];
      end
    endfunction

    // Repeated division: remainders come out least significant first and
    // are queued most significant first, the final one carrying the mark.
    function void note_value(input value_t v);
      logic [RADIX_W-1:0] base;
      value_t             quot;
      logic [DIGIT_W-1:0] rems[$];
      digit_word_t        w;
      base = radix_reg;
      if (radix_reg < RADIX_MIN) begin
        base = RADIX_MIN;
      end else if (radix_reg > RADIX_MAX) begin
        base = RADIX_MAX;
      end
      quot = v;
      if (quot == '0) begin
        rems.push_back('0);
      end
      while (quot != '0 && rems.size() < MAX_DIGITS) begin
        rems.push_back(DIGIT_W'(quot % base));
        quot = quot / base;
      end
      for (int k = rems.size() - 1; k >= 0; k--) begin
        w.digit = rems[k];
        w.last  = (k == 0);
        pending_digits.push_back(w);
      end
    endfunction

    task flag_mismatch(input string msg);
      if (errors < MAX_PRINTED) begin
        $display("mismatch at %0t: %s", $time, msg);
      end
      errors++;
    endtask

    task check_digit(input logic [DIGIT_W-1:0] digit, input logic last);
      digit_word_t w;
      if (pending_digits.size() == 0) begin
        flag_mismatch($sformatf("digit %0d (last %0b) with nothing expected", digit, last));
      end else begin
        w = pending_digits.pop_front();
        if (digit !== w.digit) begin
          flag_mismatch($sformatf("digit %0d, expected %0d", digit, w.digit));
        end
        if (last !== w.last) begin
          flag_mismatch($sformatf("last_digit %0b, expected %0b", last, w.last));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Configuration port.
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Input channel: one value per word.
  logic   in_valid = 1'b0;
  logic   in_stall;
  value_t value    = '0;

  // Output channel: one digit per word.
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;

  digit_scoreboard sb;
  int unsigned     cycle_count = 0;

  radix_digit_converter_core #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit     (digit),
    .last_digit(last_digit)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Guard against a hang: the run is ended as a failure if it overruns.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Both channels are observed at the rising edge, before any of the
  // block's own registers take their new values. An accepted value is
  // handed to the scoreboard first, so its digits queue behind any older
  // ones still outstanding.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_value(value);
      end
      if (out_valid && !out_stall) begin
        sb.check_digit(digit, last_digit);
      end
    end
  end

  // The receiver stalls on a pattern of its own that changes every so
  // often: no stall at all, occasional stalls, mostly stalled, or a regular
  // one-in-four opening. The changes fall at arbitrary points in the
  // read-back of a value, so stalls land on every digit position.
  int stall_mode = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= (stall_left % 4 != 0);
      end
    endcase
  end

  // Present one value and hold it until the block takes it. The valid
  // stays high afterwards, so back-to-back words follow without a gap.
  task automatic send_value(input value_t v);
    @(negedge clk);
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Leave the input channel empty for a number of cycles. The payload is
  // scrambled while valid is low, which the block must ignore.
  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      value    <= value_t'($urandom());
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every expected digit has come out, then wait
  // out the settle time as well so the block is truly idle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_digits.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A write goes through a setup phase and an access phase. The upper data bits
  // are random, as only the low four bits belong to the radix.
  task automatic write_register(input int unsigned index, input logic [RADIX_W-1:0] field);
    logic [APB_DATA_W-1:0] data;
    data = $urandom();
    data[RADIX_W-1:0] = field;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(index * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    sb.write_reg(index, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Registers are only touched once the block has finished all its work.
  task automatic set_radix(input logic [RADIX_W-1:0] field);
    drain_results();
    write_register(REG_RADIX, field);
  endtask

  // Full-width random values half the time, with small numbers, zero, all ones and
  // values around powers of two mixed in for short and boundary digit runs.
  function automatic value_t pick_value();
    value_t v;
    case ($urandom_range(0, 9))
      5: v = value_t'($urandom_range(0, 100));
      6: v = '1;
      7: v = (value_t'(1) << $urandom_range(0, VALUE_BITS - 1)) - value_t'($urandom_range(0, 1));
      8: v = '0;
      9: v = value_t'($urandom_range(0, 2000));
      default: v = value_t'($urandom());
    endcase
    return v;
  endfunction

  // Random bursts of values with random gaps. Some gaps are short, some
  // span a large part of one conversion, and some bursts run without gaps.
  // On request the sender pauses once midway until all digits have come.
  task automatic run_phase(input int count, input bit pause_midway);
    int  sent   = 0;
    int  burst;
    bit  paused = 1'b0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < count) begin
        send_value(pick_value());
        sent++;
        burst--;
      end
      if (pause_midway && !paused && sent >= count / 2) begin
        drain_results();
        paused = 1'b1;
      end
      case ($urandom_range(0, 7))
        3, 4, 5: idle_input($urandom_range(1, 6));
        6:       idle_input($urandom_range(20, 60));
        7:       idle_input($urandom_range(100, 250));
        default: ;
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Radix is at its reset value of two: zero gives a
    // single digit, the largest value gives the longest run of digits.
    send_value('0);
    send_value(value_t'(1));
    send_value('1);
    send_value(value_t'(1) << (VALUE_BITS - 1));

    // Base nine, the largest useful base, around its own powers.
    set_radix(RADIX_MAX);
    send_value('1);
    send_value(value_t'(8));
    send_value(value_t'(9));
    send_value(value_t'(80));

    // Register values below two behave as base two.
    set_radix(4'd0);
    send_value(value_t'(5));
    set_radix(4'd1);
    send_value(value_t'(6));

    // Register values above nine behave as base nine.
    set_radix(4'd15);
    send_value('1);
    send_value('0);
    set_radix(4'd10);
    send_value(value_t'(81));

    // A write past the register map must leave the radix alone.
    drain_results();
    write_register(SPARE_INDEX, 4'd3);
    send_value(value_t'(7));

    set_radix(4'd3);
    send_value('1);
    set_radix(4'd7);
    send_value(value_t'(32'h5555_5555));

    // Random part: about 250 values over several radix settings, the extremes
    // first, then settings across the whole register range, some of them random.
    set_radix(RADIX_MIN);
    run_phase(42, 1'b0);
    set_radix(RADIX_MAX);
    run_phase(42, 1'b0);
    set_radix(RADIX_W'($urandom_range(0, 15)));
    run_phase(42, 1'b1);
    set_radix(RADIX_W'($urandom_range(0, 15)));
    run_phase(42, 1'b0);
    set_radix(4'd15);
    run_phase(41, 1'b0);
    set_radix(RADIX_W'($urandom_range(2, 9)));
    run_phase(41, 1'b0);

    drain_results();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
